// File: rtl/core/hta_pkg.sv
// ----------------------------------------------------------------------------
// hta_pkg
// Shared types and constants of the handle table: table size, handle width,
// operation and status codes, scan token, entry and commit structs.
// ----------------------------------------------------------------------------
`default_nettype none

package hta_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int HANDLE_WIDTH  = 16;
  localparam int GLOBAL_WIDTH  = 16;
  localparam int OP_WIDTH      = 2;
  localparam int STATUS_WIDTH  = 2;

  localparam logic [OP_WIDTH-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_WIDTH-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_WIDTH-1:0] OP_REMOVE = 2'd2;

  localparam logic [STATUS_WIDTH-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_MISSING = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] ST_FULL    = 2'd2;

  typedef logic [HANDLE_WIDTH-1:0] handle_t;
  typedef logic [HANDLE_WIDTH:0]   cand_t;
  typedef logic [GLOBAL_WIDTH-1:0] global_t;

  // one table entry as seen by the neighbouring cells
  typedef struct packed {
    logic    used;
    handle_t loc;
    global_t glb;
  } ent_t;

  // scan token walking down the chain
  typedef struct packed {
    logic                vld;
    logic [OP_WIDTH-1:0] op;
    handle_t             key;
    cand_t               cand;
    handle_t             largest;
    logic                hit;
    global_t             found;
  } tok_t;

  // table update broadcast to every cell
  typedef struct packed {
    logic clr_mark;
    logic shift_dn;
    logic shift_up;
  } cmt_t;

endpackage

`default_nettype wire

// File: rtl/core/hta_cell.sv
// ----------------------------------------------------------------------------
// hta_cell
// One table position: holds an entry, updates the passing scan token and
// takes part in the insert and remove shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module hta_cell
  import hta_pkg::*;
(
  input  wire  logic clk,
  input  wire  logic rst_n,
  input  wire  tok_t tok_i,
  output tok_t       tok_o,
  input  wire  ent_t prev_i,
  input  wire  ent_t next_i,
  output ent_t       ent_o,
  input  wire  cmt_t cmt_i
);

  logic    used_r;
  handle_t loc_r;
  global_t glb_r;
  logic    mark_r;
  tok_t    tok_r;
  tok_t    tok_nxt;
  handle_t largest_nxt;

  assign ent_o = '{used: used_r, loc: loc_r, glb: glb_r};
  assign tok_o = tok_r;

  always_comb begin
    tok_nxt     = tok_i;
    largest_nxt = (loc_r > tok_i.largest) ? loc_r : tok_i.largest;
    if (used_r) begin
      tok_nxt.largest = largest_nxt;
      if ({1'b0, loc_r} == tok_i.cand) begin
        tok_nxt.cand = {1'b0, largest_nxt} + cand_t'(1);
      end
      if (!tok_i.hit && loc_r == tok_i.key) begin
        tok_nxt.hit   = 1'b1;
        tok_nxt.found = glb_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  // marks the cells at and behind the first hit, they move up on a remove
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_r <= 1'b0;
    end else if (cmt_i.clr_mark) begin
      mark_r <= 1'b0;
    end else if (tok_i.vld) begin
      mark_r <= tok_nxt.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
    end else if (cmt_i.shift_dn) begin
      used_r <= prev_i.used;
    end else if (cmt_i.shift_up && mark_r) begin
      used_r <= next_i.used;
    end
  end

  always_ff @(posedge clk) begin
    if (cmt_i.shift_dn) begin
      loc_r <= prev_i.loc;
      glb_r <= prev_i.glb;
    end else if (cmt_i.shift_up && mark_r) begin
      loc_r <= next_i.loc;
      glb_r <= next_i.glb;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/handle_table_allocate_lookup.sv
// ----------------------------------------------------------------------------
// handle_table_allocate_lookup
// Local-to-global handle table, newest entry first, built as a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  channel: one transaction per operation (add, look up, remove).
//   out_* channel: exactly one result transaction per input transaction.
//   A transaction moves when valid is high and stall is low.
// Operation:
//   each accepted operation sends a scan token down the chain of
//   TABLE_ENTRIES cells, one cell per cycle; the last cell's token decides
//   the result and the table update (insert at the front or close the gap).
// Sequencing:
//   the last cell's token is turned into a result in a holding register, then
//   moved into the output register; a new operation is taken in the cycle after
//   the result enters the output register, so the chain scans one at a time.
// Reset:
//   synchronous, rst_n low; the table comes out empty and both channels idle.
// Stalls:
//   a stalled result holds in the output register; the next operation still
//   runs and its result waits in a holding register, after which in_stall
//   stays high until the output frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module handle_table_allocate_lookup
  import hta_pkg::*;
(
  input  wire  logic                    clk,
  input  wire  logic                    rst_n,
  input  wire  logic                    in_valid,
  output logic                          in_stall,
  input  wire  logic [OP_WIDTH-1:0]     in_operation,
  input  wire  logic [15:0]             in_global_handle,
  input  wire  logic [15:0]             in_local_handle,
  output logic                          out_valid,
  input  wire  logic                    out_stall,
  output logic [STATUS_WIDTH-1:0]       out_status,
  output logic [15:0]                   out_assigned_handle,
  output logic [15:0]                   out_found_global
);

  tok_t    tok_chain [TABLE_ENTRIES+1];
  ent_t    ent_chain [TABLE_ENTRIES];
  ent_t    new_ent;
  ent_t    tail_ent;
  cmt_t    cmt;
  tok_t    last_tok;

  logic    busy_r;
  tok_t    start_r;
  global_t gh_r;
  logic    in_acc;

  logic                    fin_vld_r;
  logic [STATUS_WIDTH-1:0] fin_status_r;
  handle_t                 fin_assigned_r;
  global_t                 fin_found_r;

  logic [STATUS_WIDTH-1:0] res_status;
  handle_t                 res_assigned;
  global_t                 res_found;
  logic                    full;
  logic                    out_load;

  assign in_stall = busy_r;
  assign in_acc   = in_valid && !busy_r;
  assign out_load = fin_vld_r && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r.vld <= 1'b0;
    end else begin
      start_r.vld <= in_acc;
      if (in_acc) begin
        start_r.op      <= in_operation;
        start_r.key     <= handle_t'(in_local_handle);
        start_r.cand    <= '0;
        start_r.largest <= '0;
        start_r.hit     <= 1'b0;
        start_r.found   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      gh_r <= global_t'(in_global_handle);
    end
  end

  assign tok_chain[0] = start_r;
  assign last_tok     = tok_chain[TABLE_ENTRIES];
  assign new_ent      = '{used: 1'b1, loc: last_tok.cand[HANDLE_WIDTH-1:0], glb: gh_r};
  assign tail_ent     = '{used: 1'b0, loc: '0, glb: '0};
  assign full         = ent_chain[TABLE_ENTRIES-1].used || last_tok.cand[HANDLE_WIDTH];

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    hta_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .tok_i  (tok_chain[i]),
      .tok_o  (tok_chain[i+1]),
      .prev_i ((i == 0) ? new_ent : ent_chain[(i == 0) ? 0 : i-1]),
      .next_i ((i == TABLE_ENTRIES-1) ? tail_ent
                 : ent_chain[(i == TABLE_ENTRIES-1) ? i : i+1]),
      .ent_o  (ent_chain[i]),
      .cmt_i  (cmt)
    );
  end

  // result and table update once the token has left the last cell
  always_comb begin
    res_status   = ST_MISSING;
    res_assigned = '0;
    res_found    = '0;
    cmt          = '{clr_mark: in_acc, shift_dn: 1'b0, shift_up: 1'b0};
    if (last_tok.vld) begin
      unique case (last_tok.op)
        OP_ADD: begin
          if (full) begin
            res_status = ST_FULL;
          end else begin
            res_status   = ST_OK;
            res_assigned = last_tok.cand[HANDLE_WIDTH-1:0];
            cmt.shift_dn = 1'b1;
          end
        end
        OP_LOOKUP: begin
          if (last_tok.hit) begin
            res_status = ST_OK;
            res_found  = last_tok.found;
          end
        end
        OP_REMOVE: begin
          if (last_tok.hit) begin
            res_status   = ST_OK;
            cmt.shift_up = 1'b1;
          end
        end
        default: begin
          res_status = ST_MISSING;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      fin_vld_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_acc) begin
        busy_r <= 1'b1;
      end else if (out_load) begin
        busy_r <= 1'b0;
      end
      if (last_tok.vld) begin
        fin_vld_r <= 1'b1;
      end else if (out_load) begin
        fin_vld_r <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (last_tok.vld) begin
      fin_status_r   <= res_status;
      fin_assigned_r <= res_assigned;
      fin_found_r    <= res_found;
    end
    if (out_load) begin
      out_status          <= fin_status_r;
      out_assigned_handle <= 16'(fin_assigned_r);
      out_found_global    <= 16'(fin_found_r);
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/hta_chk.sv
// ----------------------------------------------------------------------------
// hta_chk
// Port-level checks of the handle table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hta_chk
  import hta_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_valid,
  input wire logic                    in_stall,
  input wire logic                    out_valid,
  input wire logic                    out_stall,
  input wire logic [STATUS_WIDTH-1:0] out_status,
  input wire logic [15:0]             out_assigned_handle,
  input wire logic [15:0]             out_found_global
);

  // one operation in flight at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an operation is in flight");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_MISSING
                   || out_status == ST_FULL))
    else $error("undefined status code");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK
      |-> out_assigned_handle == '0 && out_found_global == '0)
    else $error("failed transaction carries a handle");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_assigned_handle) && $stable(out_found_global))
    else $error("stalled result changed");

endmodule

bind handle_table_allocate_lookup hta_chk u_hta_chk (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_status          (out_status),
  .out_assigned_handle (out_assigned_handle),
  .out_found_global    (out_found_global)
);

`default_nettype wire

// File: bench/tb_handle_table_allocate_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_handle_table_allocate_lookup
// Self-checking bench for the local-to-global handle table: a scoreboard keeps
// its own newest-first copy of the table, predicts every add, look-up and
// remove, and compares each result transaction field by field. A directed
// opening covers the empty and full table, handle reuse and field extremes;
// a random body sweeps the table between filling and draining phases, with
// random gaps on the input side and random stalls on the result side.
// ----------------------------------------------------------------------------

module tb_handle_table_allocate_lookup;
  import hta_pkg::*;

  localparam logic [OP_WIDTH-1:0] OP_UNKNOWN = 2'd3;
  localparam int RANDOM_ITEMS = 573;
  localparam int IDLE_LIMIT   = 4000;

  typedef struct {
    logic [STATUS_WIDTH-1:0] status;
    handle_t                 assigned;
    global_t                 found;
  } table_result_t;

  class handle_scoreboard;
    handle_t       loc_q[$];
    global_t       glb_q[$];
    table_result_t want_q[$];
    int errors;
    int checked;
    int n_ok;
    int n_missing;
    int n_full;

    // apply one accepted operation to the table copy and queue its answer
    function void note_input(logic [OP_WIDTH-1:0] op, global_t gh, handle_t lh);
      table_result_t r;
      cand_t         cand;
      handle_t       largest;
      int            pos;
      r.status = ST_MISSING;
      r.assigned = '0;
      r.found = '0;
      cand = '0;
      largest = '0;
      pos = -1;
      case (op)
        OP_ADD: begin
          foreach (loc_q[i]) begin
            if (loc_q[i] > largest) largest = loc_q[i];
            if (cand == {1'b0, loc_q[i]}) cand = {1'b0, largest} + 1'b1;
          end
          // top bit of the candidate set means it left the handle range
          if (loc_q.size() >= TABLE_ENTRIES || cand[HANDLE_WIDTH]) begin
            r.status = ST_FULL;
          end else begin
            loc_q.push_front(cand[HANDLE_WIDTH-1:0]);
            glb_q.push_front(gh);
            r.status = ST_OK;
            r.assigned = cand[HANDLE_WIDTH-1:0];
          end
        end
        OP_LOOKUP, OP_REMOVE: begin
          foreach (loc_q[i]) begin
            if (pos < 0 && loc_q[i] == lh) pos = i;
          end
          if (pos >= 0) begin
            r.status = ST_OK;
            if (op == OP_LOOKUP) begin
              r.found = glb_q[pos];
            end else begin
              loc_q.delete(pos);
              glb_q.delete(pos);
            end
          end
        end
        default: ;
      endcase
      case (r.status)
        ST_OK:   n_ok++;
        ST_FULL: n_full++;
        default: n_missing++;
      endcase
      want_q.push_back(r);
    endfunction

    function void check_result(logic [STATUS_WIDTH-1:0] status, handle_t assigned,
                               global_t found);
      table_result_t w;
      if (want_q.size() == 0) begin
        errors++;
        $error("result transaction with nothing outstanding");
        return;
      end
      w = want_q.pop_front();
      checked++;
      if (status !== w.status) begin
        errors++;
        $error("status mismatch: expected %0d, actual %0d", w.status, status);
      end
      if (assigned !== w.assigned) begin
        errors++;
        $error("assigned_handle mismatch: expected %0d, actual %0d", w.assigned, assigned);
      end
      if (found !== w.found) begin
        errors++;
        $error("found_global mismatch: expected %0d, actual %0d", w.found, found);
      end
    endfunction

    function int pending();
      return want_q.size();
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [OP_WIDTH-1:0]     in_operation = OP_LOOKUP;
  logic [15:0]             in_global_handle = '0;
  logic [15:0]             in_local_handle = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [STATUS_WIDTH-1:0] out_status;
  logic [15:0]             out_assigned_handle;
  logic [15:0]             out_found_global;

  handle_scoreboard sb;
  int items_sent = 0;

  handle_table_allocate_lookup dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_global_handle    (in_global_handle),
    .in_local_handle     (in_local_handle),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_assigned_handle (out_assigned_handle),
    .out_found_global    (out_found_global)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // every third stretch of 64 transactions runs back to back
  function automatic int next_gap(int idx);
    int r;
    r = $urandom_range(0, 99);
    if ((idx / 64) % 3 == 0) return 0;
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 60);
  endfunction

  task automatic send_op(logic [OP_WIDTH-1:0] op, global_t gh, handle_t lh);
    int gap;
    gap = next_gap(items_sent);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_global_handle <= gh;
    in_local_handle <= lh;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(op, gh, lh);
    items_sent++;
  endtask

  // phases lean towards filling, mixing or draining the table
  task automatic send_random_op(int idx);
    logic [OP_WIDTH-1:0] op;
    global_t             gh;
    handle_t             lh;
    int                  r;
    int                  fill_pct;
    case ((idx / 40) % 3)
      0:       fill_pct = 85;
      1:       fill_pct = 50;
      default: fill_pct = 15;
    endcase
    r = $urandom_range(0, 99);
    if (r < 3) op = OP_UNKNOWN;
    else if ($urandom_range(0, 99) < fill_pct) op = OP_ADD;
    else if ($urandom_range(0, 1) == 1) op = OP_LOOKUP;
    else op = OP_REMOVE;
    gh = global_t'($urandom);
    r = $urandom_range(0, 99);
    if (sb.loc_q.size() > 0 && r < 70) lh = sb.loc_q[$urandom_range(0, sb.loc_q.size() - 1)];
    else if (r < 85) lh = handle_t'($urandom_range(0, 31));
    else lh = handle_t'($urandom);
    send_op(op, gh, lh);
  endtask

  // result side: short stalls mostly, a few long ones, calm stretches between
  initial begin
    int n;
    int run;
    wait (rst_n);
    forever begin
      n = $urandom_range(0, 99);
      if (n < 40) n = 0;
      else if (n < 85) n = $urandom_range(1, 3);
      else if (n < 97) n = $urandom_range(4, 10);
      else n = $urandom_range(20, 60);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 8);
      repeat (run) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_status, out_assigned_handle, out_found_global);
  end

  // ends the run when neither channel has moved a transaction for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int k;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // empty table, then handle reuse after removal
    send_op(OP_LOOKUP, 16'h0000, 16'h0000);
    send_op(OP_REMOVE, 16'hFFFF, 16'h0000);
    send_op(OP_ADD, 16'hFFFF, 16'hFFFF);
    send_op(OP_ADD, 16'h0000, 16'h0000);
    send_op(OP_ADD, 16'h1234, 16'h5A5A);
    send_op(OP_LOOKUP, 16'h0000, 16'h0001);
    send_op(OP_LOOKUP, 16'h0000, 16'hFFFF);
    send_op(OP_REMOVE, 16'h0000, 16'h0001);
    send_op(OP_ADD, 16'hBEEF, 16'h0000);
    send_op(OP_REMOVE, 16'h0000, 16'h0000);
    send_op(OP_ADD, 16'h8001, 16'h0000);
    send_op(OP_UNKNOWN, 16'hFFFF, 16'h0000);
    // fill to the brim, then one add too many
    for (k = 0; k < 13; k++) send_op(OP_ADD, global_t'(16'hA000 + k), 16'h0000);
    send_op(OP_ADD, 16'h7777, 16'h0000);
    send_op(OP_LOOKUP, 16'h0000, 16'h0002);

    for (k = 0; k < RANDOM_ITEMS; k++) send_random_op(k);
    in_valid <= 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    repeat (TABLE_ENTRIES + 8) @(posedge clk);

    $display("covered %0d operations: %0d ok, %0d not found, %0d table full",
             items_sent, sb.n_ok, sb.n_missing, sb.n_full);
    $display("%0d results compared, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
